[src/eased_fade_timer_defines.svh]
// Assertion macros for the eased fade timer.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef EASED_FADE_TIMER_DEFINES_SVH
`define EASED_FADE_TIMER_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define EFT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence on the same edge.
`define EFT_ASSERT_IMPLIES(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

[src/efade_pkg.sv]
// Shared constants, codes and types for the eased fade timer.
// No dependencies; imported by the top level.
package efade_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TIME_WIDTH = 32;

    // phase and alpha are Q1.FRAC_BITS
    localparam int P_W       = FRAC_BITS + 1;
    localparam int SQ_W      = 2 * P_W;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [P_W-1:0] ONE_Q = P_W'(1) << FRAC_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int SHAPE_W    = 3;
    localparam int S_DATA_W   = ((TIME_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W   = ((P_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DURATION = 2'd0,
        CFG_SHAPE    = 2'd1,
        CFG_GROWING  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_STOP  = 2'd1,
        REQ_TICK  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        EV_STARTED = 2'd0,
        EV_UPDATED = 2'd1,
        EV_ENDED   = 2'd2
    } event_t;

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_ZERO   = 3'd0,
        SHAPE_ONE    = 3'd1,
        SHAPE_LINEAR = 3'd2,
        SHAPE_QIN    = 3'd3,
        SHAPE_QOUT   = 3'd4,
        SHAPE_QINOUT = 3'd5
    } shape_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

endpackage

[src/eased_fade_timer.sv]
// Eased fade timer: elapsed-time tracking, bit-serial phase divide and easing.
// Depends on efade_pkg and eased_fade_timer_defines.svh.
//
//  channel  | direction | signals                          | contents
//  ---------+-----------+----------------------------------+---------------------------------
//  s        | in        | s_tvalid s_tready s_tdata s_tuser | tdata delta_time, tuser req_type
//  m        | out       | m_tvalid m_tready m_tdata m_tuser | tdata alpha, tuser kind+running
//  cfg      | in        | cfg_we cfg_index cfg_data        | duration, curve_shape, growing
//
// Start and stop pass through the MUL and FIN states before their result is registered on m;
// a tick while running passes through CHECK, the DIV_STEPS steps of the radix-2 divider that
// forms one phase bit per cycle (skipped if the run ends), MUL and FIN. s_tready rises as the
// result is registered and the sequencer returns to idle; a word with no result stays in idle.
// A finished result waits in the output register; while it waits, the next result holds
// in the sequencer and s_tready stays low.
// Reset clears the timer to idle and loads the register defaults; no clearing pass.
`include "eased_fade_timer_defines.svh"

module eased_fade_timer
    import efade_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [31:0] delta_time
    input  logic [1:0]            s_tuser,   // [1:0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [16:0] alpha, rest zero
    output logic [2:0]            m_tuser,   // [1:0] event_kind, [2] is_running
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_WIDTH-1:0] cfg_data
);

    state_t                 state_reg,    state_next;
    logic [TIME_WIDTH-1:0]  dur_reg;
    logic [SHAPE_W-1:0]     shape_reg;
    logic                   grow_reg;
    logic [TIME_WIDTH-1:0]  elapsed_reg,  elapsed_next;
    logic                   running_reg,  running_next;
    logic [TIME_WIDTH:0]    rem_reg,      rem_next;
    logic [P_W-1:0]         phase_reg,    phase_next;
    logic [CNT_W-1:0]       cnt_reg,      cnt_next;
    logic [1:0]             kind_reg,     kind_next;
    logic [SQ_W-1:0]        sq_reg,       sq_next;
    logic                   ovalid_reg,   ovalid_next;
    logic [P_W-1:0]         alpha_reg,    alpha_next;
    logic [1:0]             okind_reg,    okind_next;
    logic                   orun_reg,     orun_next;

    logic [TIME_WIDTH-1:0]  dur_eff;
    logic [TIME_WIDTH:0]    tick_sum;
    logic [TIME_WIDTH:0]    trial;
    logic                   trial_ge;
    logic [P_W-1:0]         sq_op;
    logic                   below_half;
    logic [P_W-1:0]         curve;
    logic                   accept;
    logic                   out_free;

    // Treat a zero duration as one
    assign dur_eff = (dur_reg == '0) ? TIME_WIDTH'(1) : dur_reg;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Saturating elapsed-time add
    assign tick_sum = {1'b0, elapsed_reg} + {1'b0, s_tdata[TIME_WIDTH-1:0]};

    // Radix-2 divide step: no shift on the first step, since elapsed <= duration
    assign trial    = (cnt_reg == CNT_W'(DIV_STEPS - 1)) ? rem_reg
                                                         : {rem_reg[TIME_WIDTH-1:0], 1'b0};
    assign trial_ge = (trial >= {1'b0, dur_eff});

    // Pick the squaring operand: p or one minus p
    assign below_half = (phase_reg[FRAC_BITS:FRAC_BITS-1] == 2'b00);
    always_comb
    begin
        if (shape_reg == SHAPE_QIN || (shape_reg == SHAPE_QINOUT && below_half))
            sq_op = phase_reg;
        else
            sq_op = ONE_Q - phase_reg;
    end

    // Shape the square into the curve value and apply inversion
    always_comb
    begin
        unique case (shape_reg)
            SHAPE_ZERO:   curve = '0;
            SHAPE_LINEAR: curve = grow_reg ? phase_reg : ONE_Q - phase_reg;
            SHAPE_QIN:
            begin
                curve = sq_reg[FRAC_BITS +: P_W];
                if (!grow_reg)
                    curve = ONE_Q - curve;
            end
            SHAPE_QOUT:
            begin
                curve = ONE_Q - sq_reg[FRAC_BITS +: P_W];
                if (!grow_reg)
                    curve = ONE_Q - curve;
            end
            SHAPE_QINOUT:
            begin
                if (below_half)
                    curve = sq_reg[FRAC_BITS-1 +: P_W];
                else
                    curve = ONE_Q - sq_reg[FRAC_BITS-1 +: P_W];
                if (!grow_reg)
                    curve = ONE_Q - curve;
            end
            default:      curve = ONE_Q;
        endcase
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        running_next = running_reg;
        rem_next     = rem_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        kind_next    = kind_reg;
        sq_next      = sq_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        alpha_next   = alpha_reg;
        okind_next   = okind_reg;
        orun_next    = orun_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority case (s_tuser)
                        REQ_START:
                        begin
                            if (!running_reg)
                            begin
                                running_next = 1'b1;
                                elapsed_next = '0;
                                phase_next   = '0;
                                kind_next    = EV_STARTED;
                                state_next   = ST_MUL;
                            end
                        end
                        REQ_STOP:
                        begin
                            if (running_reg)
                            begin
                                running_next = 1'b0;
                                phase_next   = ONE_Q;
                                kind_next    = EV_ENDED;
                                state_next   = ST_MUL;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (running_reg)
                            begin
                                elapsed_next = tick_sum[TIME_WIDTH] ? '1
                                                                    : tick_sum[TIME_WIDTH-1:0];
                                state_next   = ST_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK:
            begin
                // End the run once elapsed passes the duration
                if (elapsed_reg > dur_eff)
                begin
                    running_next = 1'b0;
                    phase_next   = ONE_Q;
                    kind_next    = EV_ENDED;
                    state_next   = ST_MUL;
                end
                else
                begin
                    rem_next   = {1'b0, elapsed_reg};
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                    kind_next  = EV_UPDATED;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Shift one quotient bit into the phase register per cycle
                rem_next   = trial_ge ? trial - {1'b0, dur_eff} : trial;
                phase_next = {phase_reg[P_W-2:0], trial_ge};
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                sq_next    = SQ_W'(sq_op) * SQ_W'(sq_op);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    alpha_next  = curve;
                    okind_next  = kind_reg;
                    orun_next   = running_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            running_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            dur_reg     <= TIME_WIDTH'(1000);
            shape_reg   <= SHAPE_ONE;
            grow_reg    <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            running_reg <= running_next;
            ovalid_reg  <= ovalid_next;
            if (cfg_we)
            begin
                priority case (cfg_index)
                    CFG_DURATION: dur_reg   <= cfg_data;
                    CFG_SHAPE:    shape_reg <= cfg_data[SHAPE_W-1:0];
                    CFG_GROWING:  grow_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        kind_reg  <= kind_next;
        sq_reg    <= sq_next;
        alpha_reg <= alpha_next;
        okind_reg <= okind_next;
        orun_reg  <= orun_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(M_DATA_W - P_W){1'b0}}, alpha_reg};
    assign m_tuser  = {orun_reg, okind_reg};

    // Running flag agrees with the event kind on every result
    `EFT_ASSERT_IMPLIES(a_run_kind, m_tvalid, m_tuser[2] == (m_tuser[1:0] != EV_ENDED), "run flag")
    // Alpha never exceeds one
    `EFT_ASSERT_IMPLIES(a_alpha_range, m_tvalid, alpha_reg <= ONE_Q, "alpha above one")
    // Divider only works on a running timer
    `EFT_ASSERT_IMPLIES(a_div_running, state_reg == ST_DIV, running_reg, "divide while idle")
    // The elapsed check follows directly from an accepted word
    `EFT_ASSERT_IMPLIES(a_check_accept, state_reg == ST_CHECK, $past(accept), "check no accept")

endmodule
